// ===== hw/rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse press decoder package
// Shared types, register codes and the letter code table used by the press
// decoder block.
// ----------------------------------------------------------------------------
package mpd_pkg;

  // Longest letter code that can still decode to a valid letter.
  localparam int MAX_CODE_LEN = 4;
  // The length counter must hold MAX_CODE_LEN plus one.
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 2);
  localparam int NUM_LETTERS  = 26;
  localparam int IDX_W        = 5;
  localparam int MS_W         = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // Register reset values.
  localparam logic [MS_W-1:0] DOT_LIMIT_RST  = 16'd250;
  localparam logic [MS_W-1:0] DASH_LIMIT_RST = 16'd700;
  localparam logic [MS_W-1:0] LETTER_GAP_RST = 16'd400;

  // Register index, taken from the word address.
  typedef enum logic [1:0] {
    REG_DOT_LIMIT  = 2'd0,
    REG_DASH_LIMIT = 2'd1,
    REG_LETTER_GAP = 2'd2
  } reg_idx_t;

  // Press classification.
  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_DOT  = 2'd1,
    SYM_DASH = 2'd2,
    SYM_ERR  = 2'd3
  } sym_t;

  // Configuration as seen by the decode logic.
  typedef struct packed {
    logic [MS_W-1:0] dot_limit_ms;
    logic [MS_W-1:0] dash_limit_ms;
    logic [MS_W-1:0] letter_gap_ms;
  } cfg_t;

  // One result word.
  typedef struct packed {
    sym_t             symbol;
    logic             letter_done;
    logic             letter_valid;
    logic [IDX_W-1:0] letter_index;
  } result_t;

  // Outcome of a table search.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  // Code length of each letter, A to Z.
  localparam logic [LEN_W-1:0] LETTER_LEN [NUM_LETTERS] = '{
    LEN_W'(2), LEN_W'(4), LEN_W'(4), LEN_W'(3), LEN_W'(1), LEN_W'(4), LEN_W'(3),
    LEN_W'(4), LEN_W'(2), LEN_W'(4), LEN_W'(3), LEN_W'(4), LEN_W'(2), LEN_W'(2),
    LEN_W'(3), LEN_W'(4), LEN_W'(4), LEN_W'(3), LEN_W'(3), LEN_W'(1), LEN_W'(3),
    LEN_W'(4), LEN_W'(3), LEN_W'(4), LEN_W'(4), LEN_W'(4)
  };

  // Code pattern of each letter: first symbol in bit 0, a dash is a one.
  localparam logic [MAX_CODE_LEN-1:0] LETTER_PAT [NUM_LETTERS] = '{
    MAX_CODE_LEN'(2),  MAX_CODE_LEN'(1),  MAX_CODE_LEN'(5),  MAX_CODE_LEN'(1),
    MAX_CODE_LEN'(0),  MAX_CODE_LEN'(4),  MAX_CODE_LEN'(3),  MAX_CODE_LEN'(0),
    MAX_CODE_LEN'(0),  MAX_CODE_LEN'(14), MAX_CODE_LEN'(5),  MAX_CODE_LEN'(2),
    MAX_CODE_LEN'(3),  MAX_CODE_LEN'(1),  MAX_CODE_LEN'(7),  MAX_CODE_LEN'(6),
    MAX_CODE_LEN'(11), MAX_CODE_LEN'(2),  MAX_CODE_LEN'(0),  MAX_CODE_LEN'(1),
    MAX_CODE_LEN'(4),  MAX_CODE_LEN'(8),  MAX_CODE_LEN'(6),  MAX_CODE_LEN'(9),
    MAX_CODE_LEN'(13), MAX_CODE_LEN'(3)
  };

  // Finds the first letter whose length and pattern both match.
  function automatic lookup_t mpd_lookup(input logic [LEN_W-1:0]        len,
                                         input logic [MAX_CODE_LEN-1:0] bits);
    lookup_t res;
    res = '0;
    for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
      if (LETTER_LEN[i] == len && LETTER_PAT[i] == bits) begin
        res.hit = 1'b1;
        res.idx = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mpd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Morse press decoder configuration registers
// APB-style register file holding the dot, dash and letter gap limits.
// ----------------------------------------------------------------------------
module mpd_apb_regs
  import mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t wr_idx;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_limit_ms  <= DOT_LIMIT_RST;
      cfg.dash_limit_ms <= DASH_LIMIT_RST;
      cfg.letter_gap_ms <= LETTER_GAP_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_DOT_LIMIT:  cfg.dot_limit_ms  <= pwdata[MS_W-1:0];
        REG_DASH_LIMIT: cfg.dash_limit_ms <= pwdata[MS_W-1:0];
        REG_LETTER_GAP: cfg.letter_gap_ms <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (wr_idx)
      REG_DOT_LIMIT:  prdata = {{(DATA_W-MS_W){1'b0}}, cfg.dot_limit_ms};
      REG_DASH_LIMIT: prdata = {{(DATA_W-MS_W){1'b0}}, cfg.dash_limit_ms};
      REG_LETTER_GAP: prdata = {{(DATA_W-MS_W){1'b0}}, cfg.letter_gap_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/mpd_decode_core.sv =====
// ----------------------------------------------------------------------------
// Morse press decoder core
// Classifies one press, appends it to the current letter and, when the gap
// ends the letter, looks the code up in the A to Z table.
// ----------------------------------------------------------------------------
module mpd_decode_core
  import mpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [MS_W-1:0] press_ms,
  input  logic [MS_W-1:0] gap_ms,
  input  cfg_t            cfg,
  output result_t         res
);

  logic [MAX_CODE_LEN-1:0] code_bits,   code_bits_next;
  logic [LEN_W-1:0]        code_length, code_length_next;
  logic                    error_seen,  error_seen_next;

  sym_t                    sym;
  logic [MAX_CODE_LEN-1:0] bits_app;
  logic [LEN_W-1:0]        len_app;
  logic                    err_app;
  logic                    ends_letter;
  lookup_t                 hit;

  // Press classification against the two limits.
  always_comb begin
    if (press_ms == '0) begin
      sym = SYM_NONE;
    end else if (press_ms < cfg.dot_limit_ms) begin
      sym = SYM_DOT;
    end else if (press_ms <= cfg.dash_limit_ms) begin
      sym = SYM_DASH;
    end else begin
      sym = SYM_ERR;
    end
  end

  // Letter with the new symbol appended; the length saturates one past the
  // longest valid code and no further bits are stored.
  always_comb begin
    bits_app = code_bits;
    err_app  = error_seen || (sym == SYM_ERR);
    if (code_length < LEN_W'(MAX_CODE_LEN)) begin
      for (int b = 0; b < MAX_CODE_LEN; b++) begin
        if (code_length == LEN_W'(b) && sym == SYM_DASH) begin
          bits_app[b] = 1'b1;
        end
      end
      len_app = code_length + LEN_W'(1);
    end else begin
      len_app = LEN_W'(MAX_CODE_LEN + 1);
    end
  end

  assign hit         = mpd_lookup(len_app, bits_app);
  assign ends_letter = (sym != SYM_NONE) && (gap_ms >= cfg.letter_gap_ms);

  // Result word and next letter state.
  always_comb begin
    res.symbol       = sym;
    res.letter_done  = ends_letter;
    res.letter_valid = 1'b0;
    res.letter_index = '0;
    code_bits_next   = code_bits;
    code_length_next = code_length;
    error_seen_next  = error_seen;
    if (ends_letter) begin
      if (!err_app && len_app <= LEN_W'(MAX_CODE_LEN) && hit.hit) begin
        res.letter_valid = 1'b1;
        res.letter_index = hit.idx;
      end
      code_bits_next   = '0;
      code_length_next = '0;
      error_seen_next  = 1'b0;
    end else if (sym != SYM_NONE) begin
      code_bits_next   = bits_app;
      code_length_next = len_app;
      error_seen_next  = err_app;
    end
  end

  // Letter state moves only when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits   <= '0;
      code_length <= '0;
      error_seen  <= 1'b0;
    end else if (advance) begin
      code_bits   <= code_bits_next;
      code_length <= code_length_next;
      error_seen  <= error_seen_next;
    end
  end

  // A letter can only be valid on the word that ends it.
  a_valid_needs_done: assert property (@(posedge clk) disable iff (rst)
    advance && res.letter_valid |-> res.letter_done)
    else $error("letter_valid without letter_done");

  // Ending a letter clears it.
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    advance && res.letter_done |=> code_length == '0 && code_bits == '0 && !error_seen)
    else $error("letter state not cleared after letter end");

  // A word with no press leaves the letter alone.
  a_none_holds: assert property (@(posedge clk) disable iff (rst)
    advance && res.symbol == SYM_NONE |=>
      $stable(code_length) && $stable(code_bits) && $stable(error_seen))
    else $error("letter state changed without a press");

  // The length never passes its saturation value.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    code_length <= LEN_W'(MAX_CODE_LEN + 1))
    else $error("code_length out of range");

endmodule

// ===== hw/rtl/morse_press_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Morse press decoder unit
// Turns key press and gap durations into Morse symbols and letters A to Z.
// ----------------------------------------------------------------------------
// Usage: each input word carries one press duration and the released gap that
// follows it, in milliseconds, on press_ms and gap_ms with in_valid/in_stall.
// Each accepted word yields exactly one result word on out_valid/out_stall:
// the symbol class and, when the gap ends a letter, letter_done with the
// decoded letter or an invalid flag.
// A word accepted into the input register is decoded there and lands in the
// result register once that register is free, and is visible to the receiver
// from then on. Throughput is one word per cycle while the receiver does not
// stall, set by the single decode step between those two registers.
// While the receiver stalls, the result register holds its word and one more
// word may still be taken into the input register; after that in_stall rises.
// Reset clears both registers, the letter in progress and restores the
// limits to 250, 700 and 400 ms. The user writes the limits over the APB port
// while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module morse_press_decoder_unit
  import mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MS_W-1:0]   press_ms,
  input  logic [MS_W-1:0]   gap_ms,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        symbol,
  output logic              letter_done,
  output logic              letter_valid,
  output logic [IDX_W-1:0]  letter_index,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t            cfg;
  logic            s1_valid;
  logic [MS_W-1:0] s1_press;
  logic [MS_W-1:0] s1_gap;
  logic            advance;
  logic            accept;
  result_t         res;
  result_t         out_word;

  // Configuration registers.
  mpd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input word moves on whenever the result register is free.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_press <= press_ms;
      s1_gap   <= gap_ms;
    end
  end

  // Decode logic and letter state.
  mpd_decode_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .press_ms (s1_press),
    .gap_ms   (s1_gap),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

  assign symbol       = out_word.symbol;
  assign letter_done  = out_word.letter_done;
  assign letter_valid = out_word.letter_valid;
  assign letter_index = out_word.letter_index;

endmodule
